// ----- rtl/krt_pkg.sv -----
// Shared types and codes for the keyed record table.
// Used by krt_seq and keyed_record_table_top; no dependencies.
package krt_pkg;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_SEARCH = 2'd1,
    KIND_UPDATE = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_DUP     = 2'd2,
    ST_MISSING = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_WRITE,
    S_DONE
  } seq_state_t;

  typedef struct packed {
    status_t            status;
    logic signed [31:0] quantity;
    logic [6:0]         slot;
  } result_t;

endpackage

// ----- rtl/krt_ram.sv -----
// Simple dual-port RAM: one write port, one read port with registered data.
// Holds one column of the record table; no dependencies.
module krt_ram #(
  parameter int DEPTH = 128,
  parameter int AW    = 7,
  parameter int DW    = 32
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/krt_seq.sv -----
// Request sequencer: linear key scan through the shared comparator, adder
// for updates, and write-back. Depends on krt_pkg; drives two krt_ram columns.
module krt_seq
  import krt_pkg::*;
#(
  parameter int CAPACITY = 128,
  parameter int AW       = 7,
  parameter int CW       = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_kind,
  input  logic signed [31:0] in_part_key,
  input  logic signed [31:0] in_amount,
  output logic               res_valid,
  input  logic               res_ready,
  output result_t            res,
  output logic [AW-1:0]      rd_addr,
  input  logic [31:0]        key_rd,
  input  logic [31:0]        qty_rd,
  output logic               key_we,
  output logic               qty_we,
  output logic [AW-1:0]      wr_addr,
  output logic [31:0]        key_wdata,
  output logic [31:0]        qty_wdata
);

  seq_state_t    state_r, state_nxt;
  kind_t         kind_r;
  logic [31:0]   key_r;
  logic [31:0]   amt_r;
  logic [CW-1:0] fill_r;
  logic [CW-1:0] iss_r;
  logic          chk_v_r;
  logic [AW-1:0] chk_idx_r;
  logic [AW-1:0] hit_slot_r;
  result_t       res_r;

  logic          accept;
  logic          full;
  logic          issue;
  logic          hit;
  logic          last;
  logic          req_known;
  logic [AW+6:0] chk_wide;
  logic [AW+6:0] fill_wide;

  assign full      = (fill_r == CW'(CAPACITY));
  assign accept    = in_valid && in_ready;
  assign issue     = (iss_r < fill_r);
  assign hit       = chk_v_r && (key_rd == key_r);
  assign last      = chk_v_r && ((CW'(chk_idx_r) + CW'(1)) == fill_r);
  assign req_known = (kind_t'(in_kind) == KIND_INSERT) ||
                     (kind_t'(in_kind) == KIND_SEARCH) ||
                     (kind_t'(in_kind) == KIND_UPDATE);
  assign chk_wide  = {7'd0, chk_idx_r};
  assign fill_wide = {7'd0, fill_r[AW-1:0]};
  assign rd_addr   = iss_r[AW-1:0];
  assign res       = res_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (!req_known) begin
            state_nxt = S_DONE;
          end else if (kind_t'(in_kind) == KIND_INSERT && full) begin
            state_nxt = S_DONE;
          end else if (fill_r == '0) begin
            state_nxt = (kind_t'(in_kind) == KIND_INSERT) ? S_WRITE : S_DONE;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (hit) begin
          state_nxt = (kind_r == KIND_UPDATE) ? S_WRITE : S_DONE;
        end else if (last) begin
          state_nxt = (kind_r == KIND_INSERT) ? S_WRITE : S_DONE;
        end
      end
      S_WRITE: state_nxt = S_DONE;
      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready  = 1'b0;
    res_valid = 1'b0;
    key_we    = 1'b0;
    qty_we    = 1'b0;
    wr_addr   = hit_slot_r;
    key_wdata = key_r;
    qty_wdata = res_r.quantity;
    case (state_r)
      S_IDLE:  in_ready = 1'b1;
      S_WRITE: begin
        qty_we = 1'b1;
        if (kind_r == KIND_INSERT) begin
          key_we    = 1'b1;
          wr_addr   = fill_r[AW-1:0];
          qty_wdata = amt_r;
        end
      end
      S_DONE:  res_valid = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fill_r  <= '0;
      chk_v_r <= 1'b0;
      iss_r   <= '0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        S_IDLE: begin
          chk_v_r <= 1'b0;
          iss_r   <= '0;
        end
        S_SCAN: begin
          // Hold the issue pointer at the fill mark; each slot is compared in the cycle after its read is issued.
          chk_v_r <= issue && !hit && !last;
          if (issue) begin
            iss_r <= iss_r + CW'(1);
          end
        end
        S_WRITE: begin
          if (kind_r == KIND_INSERT) begin
            fill_r <= fill_r + CW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // Request and result datapath
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          kind_r         <= kind_t'(in_kind);
          key_r          <= in_part_key;
          amt_r          <= in_amount;
          res_r.status   <= (kind_t'(in_kind) == KIND_INSERT && full) ? ST_FULL : ST_MISSING;
          res_r.quantity <= '0;
          res_r.slot     <= '0;
        end
      end
      S_SCAN: begin
        chk_idx_r <= iss_r[AW-1:0];
        if (hit) begin
          hit_slot_r <= chk_idx_r;
          case (kind_r)
            KIND_INSERT: res_r.status <= ST_DUP;
            KIND_SEARCH: begin
              res_r.status   <= ST_OK;
              res_r.quantity <= qty_rd;
              res_r.slot     <= chk_wide[6:0];
            end
            KIND_UPDATE: begin
              res_r.status   <= ST_OK;
              res_r.quantity <= qty_rd + amt_r;
              res_r.slot     <= chk_wide[6:0];
            end
            default: ;
          endcase
        end
      end
      S_WRITE: begin
        if (kind_r == KIND_INSERT) begin
          res_r.status   <= ST_OK;
          res_r.quantity <= amt_r;
          res_r.slot     <= fill_wide[6:0];
        end
      end
      default: ;
    endcase
  end

endmodule

// ----- rtl/keyed_record_table_top.sv -----
// Keyed record table: linear-search key/quantity store, one request at a time.
// Depends on krt_pkg, krt_ram and krt_seq.
//
// Usage:
//   Input channel in_valid/in_ready carries in_kind (0 insert, 1 search,
//   2 update), in_part_key and in_amount. Each transfer yields exactly one
//   result on out_valid/out_ready: out_status, out_quantity, out_slot.
//   Requests are handled one at a time; in_ready is high only while the
//   sequencer is idle.
// Scan: the scan reads one slot per cycle from the key and quantity RAMs,
//   whose read data is registered. A request that hits ends the scan at its
//   slot (an update then adds a write-back); a miss scans all filled slots
//   (an insert then adds a write-back). A full-table insert, an unused kind
//   or an empty table finishes without a scan.
// Reset: rst_n (synchronous, active low) empties the table (fill count zero).
//   Memory contents are not cleared; only filled slots are ever compared.
// Stall: the result sits in an output register; the next request is taken
//   while it waits, and its own result holds in the sequencer until it frees.
module keyed_record_table_top
  import krt_pkg::*;
#(
  parameter int CAPACITY = 128
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_kind,
  input  logic signed [31:0] in_part_key,
  input  logic signed [31:0] in_amount,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_status,
  output logic signed [31:0] out_quantity,
  output logic [6:0]         out_slot
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  logic          res_valid;
  logic          res_ready;
  result_t       res;
  logic [AW-1:0] rd_addr;
  logic [31:0]   key_rd;
  logic [31:0]   qty_rd;
  logic          key_we;
  logic          qty_we;
  logic [AW-1:0] wr_addr;
  logic [31:0]   key_wdata;
  logic [31:0]   qty_wdata;

  logic          out_valid_r;
  result_t       out_res_r;

  krt_seq #(
    .CAPACITY (CAPACITY),
    .AW       (AW),
    .CW       (CW)
  ) u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_kind     (in_kind),
    .in_part_key (in_part_key),
    .in_amount   (in_amount),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res),
    .rd_addr     (rd_addr),
    .key_rd      (key_rd),
    .qty_rd      (qty_rd),
    .key_we      (key_we),
    .qty_we      (qty_we),
    .wr_addr     (wr_addr),
    .key_wdata   (key_wdata),
    .qty_wdata   (qty_wdata)
  );

  krt_ram #(
    .DEPTH (CAPACITY),
    .AW    (AW),
    .DW    (32)
  ) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (wr_addr),
    .wdata (key_wdata),
    .raddr (rd_addr),
    .rdata (key_rd)
  );

  krt_ram #(
    .DEPTH (CAPACITY),
    .AW    (AW),
    .DW    (32)
  ) u_qty_ram (
    .clk   (clk),
    .we    (qty_we),
    .waddr (wr_addr),
    .wdata (qty_wdata),
    .raddr (rd_addr),
    .rdata (qty_rd)
  );

  // Load the output register when it is empty or being drained this cycle.
  assign res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_status   = out_res_r.status;
  assign out_quantity = out_res_r.quantity;
  assign out_slot     = out_res_r.slot;

endmodule

// ----- dv/tb_keyed_record_table_top.sv -----
// Self-checking testbench for keyed_record_table_top: a directed pass, then a random mix
// of inserts, searches, updates and unused kinds, checked against a table model kept in the bench.
// Depends on krt_pkg and the keyed_record_table_top RTL.
module tb_keyed_record_table_top;
  timeunit 1ns;
  timeprecision 1ps;
  import krt_pkg::*;

  localparam int          CAPACITY    = 128;
  localparam int          RANDOM_REQS = 1830;
  localparam int          PAUSE_AT    = 1000;   // sender drains before this request
  localparam int          HOLD_AT     = 400;    // receiver holds off after this many results
  localparam int          HOLD_CYCLES = 500;
  localparam int          TAIL_CYCLES = 200;
  localparam int          LIMIT       = 2_000_000;
  localparam logic [1:0]  KIND_UNUSED = 2'd3;

  typedef struct {
    logic [1:0]  kind;
    logic [31:0] key;
    logic [31:0] amount;
  } request_t;

  logic               clk         = 1'b0;
  logic               rst_n       = 1'b0;
  logic               in_valid    = 1'b0;
  logic               in_ready;
  logic [1:0]         in_kind     = '0;
  logic signed [31:0] in_part_key = '0;
  logic signed [31:0] in_amount   = '0;
  logic               out_valid;
  logic               out_ready   = 1'b0;
  logic [1:0]         out_status;
  logic signed [31:0] out_quantity;
  logic [6:0]         out_slot;

  keyed_record_table_top #(.CAPACITY(CAPACITY)) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_kind     (in_kind),
    .in_part_key (in_part_key),
    .in_amount   (in_amount),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_status  (out_status),
    .out_quantity(out_quantity),
    .out_slot    (out_slot)
  );

  always #10 clk = ~clk;

  // Table as the bench sees it.
  logic [31:0] key_mem [CAPACITY];
  logic [31:0] qty_mem [CAPACITY];
  int          row_count = 0;

  request_t    request_q[$];
  result_t     awaited_results[$];
  logic [31:0] issued_keys[$];      // keys the generator expects to be stored

  logic in_xfer  = 1'b0;
  logic out_xfer = 1'b0;
  int   sent_count = 0;
  int   got_count = 0;
  int   error_count = 0;
  int   cycle_count = 0;
  int   send_gap = 0;
  int   ready_gap = 0;
  int   hold_left = 0;
  bit   hold_done = 0;

  function automatic result_t apply_to_table(logic [1:0] kind, logic [31:0] key,
                                             logic [31:0] amt);
    result_t r;
    int      at;
    int      i;
    r.status   = ST_MISSING;
    r.quantity = '0;
    r.slot     = '0;
    at = -1;
    for (i = 0; i < row_count; i++) begin
      if (at < 0 && key_mem[i] == key) at = i;
    end
    case (kind)
      KIND_INSERT: begin
        if (row_count >= CAPACITY) begin
          r.status = ST_FULL;
        end else if (at >= 0) begin
          r.status = ST_DUP;
        end else begin
          key_mem[row_count] = key;
          qty_mem[row_count] = amt;
          r.status   = ST_OK;
          r.quantity = amt;
          r.slot     = 7'(row_count);
          row_count++;
        end
      end
      KIND_SEARCH: begin
        if (at >= 0) begin
          r.status   = ST_OK;
          r.quantity = qty_mem[at];
          r.slot     = 7'(at);
        end
      end
      KIND_UPDATE: begin
        if (at >= 0) begin
          qty_mem[at] = qty_mem[at] + amt;
          r.status   = ST_OK;
          r.quantity = qty_mem[at];
          r.slot     = 7'(at);
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Mostly short gaps, a few long ones, and stretches with none at all.
  function automatic int pick_gap(int phase);
    int r;
    r = $urandom_range(0, 99);
    if ((phase / 150) % 4 == 2) return 0;
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [31:0] pick_word();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom;
    if (r < 85) return 32'($signed($urandom_range(0, 200)) - 100);
    case ($urandom_range(0, 3))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0000_0000;
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  function automatic bit key_issued(logic [31:0] key);
    foreach (issued_keys[i]) begin
      if (issued_keys[i] == key) return 1;
    end
    return 0;
  endfunction

  function automatic logic [31:0] known_key();
    if (issued_keys.size() == 0) return $urandom;
    return issued_keys[$urandom_range(0, issued_keys.size() - 1)];
  endfunction

  task automatic queue_request(logic [1:0] kind, logic [31:0] key, logic [31:0] amt);
    request_t req;
    req.kind   = kind;
    req.key    = key;
    req.amount = amt;
    request_q.push_back(req);
    if (kind == KIND_INSERT && issued_keys.size() < CAPACITY && !key_issued(key))
      issued_keys.push_back(key);
  endtask

  // Sender: offer the next request at the falling edge, hold it until the transfer.
  always @(negedge clk) begin
    request_t req;
    if (rst_n && (!in_valid || in_xfer)) begin
      if (in_xfer) send_gap = pick_gap(sent_count);
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (request_q.size() > 0 &&
                   !(sent_count == PAUSE_AT && awaited_results.size() != 0)) begin
        req = request_q.pop_front();
        in_kind     <= req.kind;
        in_part_key <= req.key;
        in_amount   <= req.amount;
        in_valid    <= 1'b1;
        sent_count++;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls after each transfer, plus one long hold-off.
  always @(negedge clk) begin
    if (rst_n) begin
      if (out_xfer) ready_gap = pick_gap(got_count);
      if (!hold_done && got_count >= HOLD_AT) begin
        hold_done = 1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (ready_gap > 0) begin
        ready_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Monitor: predict on each request transfer, check each result transfer.
  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      in_xfer  <= 1'b0;
      out_xfer <= 1'b0;
    end else begin
      in_xfer  <= in_valid && in_ready;
      out_xfer <= out_valid && out_ready;
      if (in_valid && in_ready)
        awaited_results.push_back(apply_to_table(in_kind, in_part_key, in_amount));
      if (out_valid && out_ready) begin
        got_count++;
        if (awaited_results.size() == 0) begin
          $display("%0t: unexpected result status=%0d quantity=%0d slot=%0d",
                   $time, out_status, out_quantity, out_slot);
          error_count++;
        end else begin
          want = awaited_results.pop_front();
          if (out_status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, out_status);
            error_count++;
          end
          if (out_quantity !== want.quantity) begin
            $display("%0t: quantity expected %0d actual %0d",
                     $time, want.quantity, out_quantity);
            error_count++;
          end
          if (out_slot !== want.slot) begin
            $display("%0t: slot expected %0d actual %0d", $time, want.slot, out_slot);
            error_count++;
          end
        end
      end
    end
  end

  initial begin
    while (cycle_count < LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb_keyed_record_table_top NOT OK");
    $finish;
  end

  initial begin
    int          r;
    int          n;
    logic [31:0] key;

    // Empty table, unused kind.
    queue_request(KIND_SEARCH, 32'h0, 32'h0);
    queue_request(KIND_UPDATE, 32'h0, 32'h5);
    queue_request(KIND_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // Extreme keys and quantities.
    queue_request(KIND_INSERT, 32'h8000_0000, 32'h7FFF_FFFF);
    queue_request(KIND_INSERT, 32'h7FFF_FFFF, 32'h8000_0000);
    queue_request(KIND_INSERT, 32'h0000_0000, 32'h0000_0000);
    queue_request(KIND_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_request(KIND_INSERT, 32'h0000_0000, 32'h1234_5678);
    queue_request(KIND_SEARCH, 32'h7FFF_FFFF, 32'hDEAD_BEEF);
    queue_request(KIND_SEARCH, 32'hFFFF_FFFF, 32'h0);
    // Wrap in both directions.
    queue_request(KIND_UPDATE, 32'h8000_0000, 32'h0000_0001);
    queue_request(KIND_UPDATE, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    queue_request(KIND_UPDATE, 32'hFFFF_FFFF, 32'h8000_0000);
    queue_request(KIND_UPDATE, 32'h0000_0000, 32'h7FFF_FFFF);
    queue_request(KIND_SEARCH, 32'h8000_0000, 32'h0);
    // Misses and the unused kind on a present key.
    queue_request(KIND_SEARCH, 32'h0000_0005, 32'h0);
    queue_request(KIND_UPDATE, 32'h0000_0005, 32'h0000_0001);
    queue_request(KIND_UNUSED, 32'h0000_0000, 32'h0000_0001);

    for (n = 0; n < RANDOM_REQS; n++) begin
      r = $urandom_range(0, 99);
      if (r < 11) begin
        // Fresh key: grows the table until it is full, then draws a full status.
        do key = pick_word(); while (key_issued(key));
        queue_request(KIND_INSERT, key, pick_word());
      end else if (r < 16) begin
        queue_request(KIND_INSERT, known_key(), pick_word());
      end else if (r < 52) begin
        queue_request(KIND_SEARCH, known_key(), pick_word());
      end else if (r < 88) begin
        queue_request(KIND_UPDATE, known_key(), pick_word());
      end else if (r < 94) begin
        queue_request($urandom_range(0, 1) ? KIND_SEARCH : KIND_UPDATE, pick_word(),
                      pick_word());
      end else begin
        queue_request(KIND_UNUSED, pick_word(), pick_word());
      end
    end

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (!(request_q.size() == 0 && !in_valid && awaited_results.size() == 0))
      @(posedge clk);
    // Catch any stray result after the last expected one.
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0)
      $display("tb_keyed_record_table_top OK");
    else
      $display("tb_keyed_record_table_top NOT OK");
    $finish;
  end

endmodule
